[sv/bounded_lifo_stack_assert.svh]
// assertion helpers shared by the stack modules
`ifndef BOUNDED_LIFO_STACK_ASSERT_SVH
`define BOUNDED_LIFO_STACK_ASSERT_SVH

// condition must never hold outside reset
`define BLS_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define BLS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define BLS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/bls_pkg.sv]
package bls_pkg;

    localparam int WORD_W     = 32;
    localparam int POS_W      = 3;
    localparam int FILL_OUT_W = 4;
    localparam int DEPTH_DEF  = 8;
    // slots reachable by a peek position
    localparam int PEEK_SPAN  = 2 ** POS_W;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_PEEK   = 2'd2,
        OP_CHANGE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    // what the cell row does this cycle
    typedef enum logic [1:0] {
        RING_HOLD  = 2'd0,
        RING_PUSH  = 2'd1,
        RING_POP   = 2'd2,
        RING_WRITE = 2'd3
    } t_ring_op;

    typedef struct packed {
        t_op                       cmd;
        logic [POS_W-1:0]          position;
        logic signed [WORD_W-1:0]  value;
    } t_cmd;

    typedef struct packed {
        logic signed [WORD_W-1:0]  data;
        t_status                   status;
        logic [FILL_OUT_W-1:0]     fill_count;
        logic                      is_empty;
        logic                      is_full;
    } t_rsp;

    typedef struct packed {
        t_ring_op                  op;
        logic signed [WORD_W-1:0]  value;
    } t_ring_ctl;

endpackage

[sv/bls_if.sv]
interface bls_cmd_if;
    import bls_pkg::*;

    logic valid;
    logic ready;
    t_cmd payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface bls_rsp_if;
    import bls_pkg::*;

    logic valid;
    logic ready;
    t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

[sv/bounded_lifo_stack.sv]
// bounded_lifo_stack: fixed-depth lifo of signed 32-bit words
//
// i_cmd  (bls_cmd_if sink): one command word per handshake, cmd selects
//        push, pop, peek at position or change at position
// o_rsp  (bls_rsp_if source): one response word per command with the
//        popped or peeked data, status, fill count and empty/full flags
//
// the stack lives in a row of DEPTH cells, cell 0 always holding the top;
// push and pop shift the whole row by one cell toward or away from the top,
// change writes the one cell that its slot currently sits in. the low slots
// reachable by a peek position are mirrored in a small register file.
//
// every command completes in the cycle it is accepted and its response is
// registered in the output register; one command per cycle while ready is high.
// if the receiver stalls, one more response parks in a skid register and
// i_cmd.ready drops until the output side drains.
// reset (synchronous, i_rst_n low) empties the stack, zeroes every slot and
// drops any pending response.
`include "bounded_lifo_stack_assert.svh"

module bounded_lifo_stack #(
    parameter int DEPTH = bls_pkg::DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bls_cmd_if.sink    i_cmd,
    bls_rsp_if.source  o_rsp
);
    import bls_pkg::*;

    localparam int IDX_W    = $clog2(DEPTH);
    localparam int FILL_W   = $clog2(DEPTH + 1);
    localparam int SUM_W    = IDX_W + 1;
    // mirrored slots: those a peek position can reach
    localparam int SHADOW_N = (DEPTH < PEEK_SPAN) ? DEPTH : PEEK_SPAN;
    localparam int SH_W     = $clog2(SHADOW_N);

    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(DEPTH);
    localparam logic [FILL_W-1:0] FILL_SH_N = FILL_W'(SHADOW_N);
    localparam logic [FILL_W-1:0] FILL_ONE  = FILL_W'(1);

    // stack state
    logic [FILL_W-1:0]        r_fill;
    logic [FILL_W-1:0]        n_fill;
    logic signed [WORD_W-1:0] r_shadow [SHADOW_N];
    logic signed [WORD_W-1:0] n_shadow [SHADOW_N];

    // cell row wiring
    logic signed [WORD_W-1:0] w_cell [DEPTH];
    logic signed [WORD_W-1:0] w_low  [DEPTH];
    logic signed [WORD_W-1:0] w_high [DEPTH];
    t_ring_ctl                w_ring;
    logic [SUM_W-1:0]         w_sum;
    logic [SUM_W-1:0]         w_wrap;
    logic [IDX_W-1:0]         w_target;

    // command decode
    t_cmd              w_cmd;
    logic              w_accept;
    logic              w_out_ready;
    logic              w_empty;
    logic              w_full;
    logic              w_pos_ok;
    logic [FILL_W-1:0] w_top_idx;
    t_rsp              w_rsp;

    assign w_cmd       = i_cmd.payload;
    assign i_cmd.ready = w_out_ready;
    assign w_accept    = i_cmd.valid && w_out_ready;

    assign w_empty   = (r_fill == '0);
    assign w_full    = (r_fill == FILL_FULL);
    assign w_top_idx = r_fill - FILL_ONE;
    // position names a mirrored slot
    assign w_pos_ok  = {1'b0, w_cmd.position} < (POS_W + 1)'(SHADOW_N);

    // slot p sits in cell (fill - 1 - p) mod DEPTH
    assign w_sum    = SUM_W'(r_fill) + SUM_W'(DEPTH - 1) - SUM_W'(w_cmd.position);
    assign w_wrap   = (w_sum >= SUM_W'(DEPTH)) ? (w_sum - SUM_W'(DEPTH)) : w_sum;
    assign w_target = w_wrap[IDX_W-1:0];

    always_comb begin
        n_fill         = r_fill;
        n_shadow       = r_shadow;
        w_ring.op      = RING_HOLD;
        w_ring.value   = w_cmd.value;
        w_rsp.data     = '0;
        w_rsp.status   = ST_OK;
        if (w_accept) begin
            case (w_cmd.cmd)
                OP_PUSH: begin
                    if (w_full) begin
                        w_rsp.status = ST_OVERFLOW;
                    end else begin
                        n_fill    = r_fill + FILL_ONE;
                        w_ring.op = RING_PUSH;
                        if (r_fill < FILL_SH_N) begin
                            n_shadow[r_fill[SH_W-1:0]] = w_cmd.value;
                        end
                    end
                end
                OP_POP: begin
                    if (w_empty) begin
                        w_rsp.status = ST_UNDERFLOW;
                    end else begin
                        n_fill     = w_top_idx;
                        w_ring.op  = RING_POP;
                        w_rsp.data = w_cell[0];
                        // popped slot reads as zero afterwards
                        if (w_top_idx < FILL_SH_N) begin
                            n_shadow[w_top_idx[SH_W-1:0]] = '0;
                        end
                    end
                end
                OP_PEEK: begin
                    if (w_empty) begin
                        w_rsp.status = ST_UNDERFLOW;
                    end else if (w_pos_ok) begin
                        w_rsp.data = r_shadow[w_cmd.position[SH_W-1:0]];
                    end
                end
                OP_CHANGE: begin
                    // no check against the top, out-of-range position ignored
                    if (w_pos_ok) begin
                        w_ring.op = RING_WRITE;
                        n_shadow[w_cmd.position[SH_W-1:0]] = w_cmd.value;
                    end
                end
                default: begin
                    w_ring.op = RING_HOLD;
                end
            endcase
        end
        w_rsp.fill_count = FILL_OUT_W'(n_fill);
        w_rsp.is_empty   = (n_fill == '0);
        w_rsp.is_full    = (n_fill == FILL_FULL);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_shadow <= '{default: '0};
        end else begin
            r_fill   <= n_fill;
            r_shadow <= n_shadow;
        end
    end

    // cell row: push moves words away from the top, pop toward it
    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            if (g == 0) begin : g_first
                assign w_low[g] = w_cmd.value;
            end else begin : g_mid_low
                assign w_low[g] = w_cell[g-1];
            end
            if (g == DEPTH - 1) begin : g_last
                assign w_high[g] = '0;
            end else begin : g_mid_high
                assign w_high[g] = w_cell[g+1];
            end

            bls_cell #(
                .IDX_W    (IDX_W),
                .CELL_IDX (g)
            ) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctl       (w_ring),
                .i_target    (w_target),
                .i_from_low  (w_low[g]),
                .i_from_high (w_high[g]),
                .o_word      (w_cell[g])
            );
        end
    endgenerate

    // response register with one word of skid
    bls_out_skid u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_word  (w_rsp),
        .o_ready (w_out_ready),
        .o_rsp   (o_rsp)
    );

    `BLS_ASSERT_NEVER(a_fill_bound, i_clk, i_rst_n, r_fill > FILL_FULL, "fill count beyond depth")
    `BLS_ASSERT_NEXT(a_push_grows, i_clk, i_rst_n, w_accept && (w_cmd.cmd == OP_PUSH) && !w_full, r_fill == $past(r_fill) + 1, "push with room did not grow the stack")

endmodule

[sv/bls_cell.sv]
module bls_cell #(
    parameter int IDX_W    = $clog2(bls_pkg::DEPTH_DEF),
    parameter int CELL_IDX = 0
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  bls_pkg::t_ring_ctl               i_ctl,
    input  logic [IDX_W-1:0]                 i_target,
    input  logic signed [bls_pkg::WORD_W-1:0] i_from_low,
    input  logic signed [bls_pkg::WORD_W-1:0] i_from_high,
    output logic signed [bls_pkg::WORD_W-1:0] o_word
);
    import bls_pkg::*;

    logic signed [WORD_W-1:0] r_word;
    logic signed [WORD_W-1:0] n_word;

    always_comb begin
        case (i_ctl.op)
            RING_PUSH:  n_word = i_from_low;
            RING_POP:   n_word = i_from_high;
            RING_WRITE: n_word = (i_target == IDX_W'(CELL_IDX)) ? i_ctl.value : r_word;
            default:    n_word = r_word;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word <= '0;
        end else begin
            r_word <= n_word;
        end
    end

    assign o_word = r_word;

endmodule

[sv/bls_out_skid.sv]
`include "bounded_lifo_stack_assert.svh"

module bls_out_skid (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  bls_pkg::t_rsp   i_word,
    output logic            o_ready,
    bls_rsp_if.source       o_rsp
);
    import bls_pkg::*;

    logic r_main_valid;
    logic r_skid_valid;
    t_rsp r_main;
    t_rsp r_skid;
    logic n_main_valid;
    logic n_skid_valid;
    t_rsp n_main;
    t_rsp n_skid;
    logic w_take;

    assign o_ready = !r_skid_valid;
    assign w_take  = i_valid && o_ready;

    always_comb begin
        n_main_valid = r_main_valid;
        n_skid_valid = r_skid_valid;
        n_main       = r_main;
        n_skid       = r_skid;
        if (!r_main_valid || o_rsp.ready) begin
            if (r_skid_valid) begin
                n_main       = r_skid;
                n_main_valid = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_main       = i_word;
                n_main_valid = w_take;
            end
        end else if (w_take) begin
            n_skid       = i_word;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= n_main_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_main <= n_main;
        r_skid <= n_skid;
    end

    assign o_rsp.valid   = r_main_valid;
    assign o_rsp.payload = r_main;

    `BLS_ASSERT_NEVER(a_skid_without_main, i_clk, i_rst_n, r_skid_valid && !r_main_valid, "skid word held with empty output register")
    `BLS_ASSERT_NEXT(a_stall_fills_skid, i_clk, i_rst_n, r_main_valid && !o_rsp.ready && w_take, r_skid_valid, "word taken during stall was not parked")
    `BLS_ASSERT_NEXT(a_empty_passes_word, i_clk, i_rst_n, w_take && !r_main_valid, r_main_valid && (r_main == $past(i_word)), "word did not reach the output register")

endmodule
